// File: design/cal_pkg.sv
// Package: shared constants, operation codes and cell control types for the cursor list.
`default_nettype none
package cal_pkg;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CUR_W = CNT_W + 1;
  localparam int OUT_W = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_FIRST  = 3'd4,
    OP_PREV   = 3'd5,
    OP_NEXT   = 3'd6,
    OP_SETPOS = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_INSERT,
    SH_APPEND,
    SH_REMOVE
  } shift_t;

  typedef struct packed {
    shift_t             kind;
    logic [CNT_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt;
    logic [WIDTH-1:0]   din;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: design/cursor_array_list_unit.sv
// Top level: cursor list control, configuration register, chain of cells and result register.
// The result of an item is loaded into the output register at its input transfer.
// Throughput: one item per cycle while in_ready is high; each shift of the cell row is registered at its transfer,
//   and in_ready stays high while the result register is empty or being drained.
// Reset (rst, synchronous, active high): length and cursor go to zero, capacity to 16,
//   the result register empties. Cell contents are not cleared.
`default_nettype none
module cursor_array_list_unit import cal_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration: capacity register
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       func,
  input  wire logic [31:0]      value,
  input  wire logic [CNT_W-1:0] position,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [OUT_W-1:0] removed_value,
  output logic      [CNT_W-1:0] length,
  output logic signed [CUR_W-1:0] cursor_now,
  output logic                  error
);

  // architectural state
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic signed [CUR_W-1:0] cursor;
  logic signed [CUR_W-1:0] cursor_next;
  logic [CNT_W-1:0]        capacity;

  logic [CNT_W-1:0]        eff_cap;
  logic                    accept;
  logic                    ins_err;
  logic                    rem_err;
  logic                    full;
  logic                    err_next;
  logic [OUT_W-1:0]        removed_next;
  logic [WIDTH-1:0]        rd_data;
  op_t                     op;
  cell_ctrl_t              ctrl;

  // result register frees up when its content is taken
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(func);

  // capacity above the cell count behaves as the cell count
  assign eff_cap = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;
  assign full    = (count >= eff_cap);

  // insert needs room and a cursor in 0..count
  assign ins_err = full || cursor[CUR_W-1] || (cursor[CNT_W-1:0] > count);
  // remove needs a cursor on an existing entry
  assign rem_err = (count == '0) || cursor[CUR_W-1] || (cursor[CNT_W-1:0] >= count);

  always_comb begin
    count_next   = count;
    cursor_next  = cursor;
    err_next     = 1'b0;
    removed_next = '0;
    ctrl.kind    = SH_NONE;
    ctrl.pos     = cursor[CNT_W-1:0];
    ctrl.cnt     = count;
    ctrl.din     = value[WIDTH-1:0];
    case (op)
      OP_INSERT: begin
        if (ins_err) begin
          err_next = 1'b1;
        end else begin
          ctrl.kind  = SH_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_APPEND: begin
        if (full) begin
          err_next = 1'b1;
        end else begin
          ctrl.kind  = SH_APPEND;
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (rem_err) begin
          err_next = 1'b1;
        end else begin
          ctrl.kind    = SH_REMOVE;
          count_next   = count - 1'b1;
          removed_next = OUT_W'(rd_data);
        end
      end
      OP_CLEAR: begin
        count_next  = '0;
        cursor_next = '0;
      end
      OP_FIRST: cursor_next = '0;
      OP_PREV: begin
        // stops at -1
        if (cursor != '1) begin
          cursor_next = cursor - 1'b1;
        end
      end
      OP_NEXT: begin
        // stops at DEPTH
        if (cursor < $signed(CUR_W'(DEPTH))) begin
          cursor_next = cursor + 1'b1;
        end
      end
      OP_SETPOS: begin
        cursor_next = (position > CNT_W'(DEPTH)) ? CUR_W'(DEPTH) : CUR_W'(position);
      end
      default: cursor_next = cursor;
    endcase
    // cells only move on a transfer
    if (!accept) begin
      ctrl.kind = SH_NONE;
    end
  end

  cal_chain u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      capacity  <= CNT_W'(16);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on every transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      length        <= count_next;
      cursor_now    <= cursor_next;
      error         <= err_next;
    end
  end

  // an accepted item always leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("no result after input transfer");

  // the list never grows past the cell row
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("length exceeds depth");

  // a good remove shrinks the list by one
  a_remove_len: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_REMOVE && !rem_err) |=> (count == $past(count) - 1'b1))
    else $error("remove did not shrink the list");

  // a rejected item reports no removed entry
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (removed_value == '0))
    else $error("rejected item carries a value");

endmodule
`default_nettype wire

// File: design/cal_cell.sv
// One list cell: holds an entry, loads new data or a neighbor's entry on a shift.
`default_nettype none
module cal_cell import cal_pkg::*; (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [WIDTH-1:0] left_data,
  input  wire logic [WIDTH-1:0] right_data,
  output logic      [WIDTH-1:0] data
);

  logic [WIDTH-1:0] data_next;
  logic [CNT_W-1:0] pos_here;

  assign pos_here = CNT_W'(idx);

  always_comb begin
    data_next = data;
    case (ctrl.kind)
      SH_INSERT: begin
        if (pos_here == ctrl.pos) begin
          data_next = ctrl.din;
        end else if (pos_here > ctrl.pos && pos_here <= ctrl.cnt) begin
          data_next = left_data;
        end
      end
      SH_APPEND: begin
        if (pos_here == ctrl.cnt) begin
          data_next = ctrl.din;
        end
      end
      SH_REMOVE: begin
        // entries above the removed one slide down
        if (pos_here >= ctrl.pos && (pos_here + 1'b1) < ctrl.cnt) begin
          data_next = right_data;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

// File: design/cal_chain.sv
// Row of list cells wired to their neighbors, plus the read of the entry at the cursor.
`default_nettype none
module cal_chain import cal_pkg::*; (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] cell_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WIDTH-1:0] left_d;
    logic [WIDTH-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    cal_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[g])
    );
  end

  // and-or select of the entry at ctrl.pos
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl.pos == CNT_W'(i)) begin
        rd_data = rd_data | cell_q[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/cursor_array_list_unit_tb.sv
// Testbench for the cursor list unit: directed table, then random traffic checked by a list predictor.
`default_nettype none
module cursor_array_list_unit_tb import cal_pkg::*; ();

  // One result transfer as the predictor sees it.
  typedef struct packed {
    logic [OUT_W-1:0] removed;
    logic [CNT_W-1:0] len;
    logic [CUR_W-1:0] cur;
    logic             err;
  } list_result_t;

  // Directed stimulus row: an operation, or a capacity write done while idle.
  typedef struct {
    bit               is_cfg;
    op_t              op;
    logic [31:0]      val;
    logic [CNT_W-1:0] pos;
    bit               typed;   // expected result written in by hand
    list_result_t     want;
  } stim_row_t;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int NUM_PHASES     = 8;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [2:0]       func      = '0;
  logic [31:0]      value     = '0;
  logic [CNT_W-1:0] position  = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OUT_W-1:0] removed_value;
  logic [CNT_W-1:0] length;
  logic signed [CUR_W-1:0] cursor_now;
  logic             error;

  cursor_array_list_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .value         (value),
    .position      (position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .removed_value (removed_value),
    .length        (length),
    .cursor_now    (cursor_now),
    .error         (error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List predictor: its own copy of the cells, length, cursor and capacity.
  // Only the driving process calls it, right at the input transfer, so the
  // random generator can shape items from the up-to-date list state.
  // ---------------------------------------------------------------------------
  logic [WIDTH-1:0] shadow_cells [DEPTH];
  int               shadow_len = 0;
  int               shadow_cur = 0;
  int               shadow_cap = 16;

  function automatic list_result_t apply_list_op(op_t op, logic [31:0] v, logic [CNT_W-1:0] p);
    list_result_t r;
    int           eff_cap;
    int           i;
    r = '0;
    // capacity above DEPTH acts as DEPTH; zero refuses every insert and append
    eff_cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= eff_cap || shadow_cur < 0 || shadow_cur > shadow_len) begin
          r.err = 1'b1;
        end else begin
          for (i = shadow_len; i > shadow_cur; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[shadow_cur] = v[WIDTH-1:0];
          shadow_len++;
        end
      end
      OP_APPEND: begin
        if (shadow_len >= eff_cap) begin
          r.err = 1'b1;
        end else begin
          shadow_cells[shadow_len] = v[WIDTH-1:0];
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        // empty list or cursor off the entries: nothing taken, value stays zero
        if (shadow_len == 0 || shadow_cur < 0 || shadow_cur >= shadow_len) begin
          r.err = 1'b1;
        end else begin
          r.removed = OUT_W'(shadow_cells[shadow_cur]);
          for (i = shadow_cur; i + 1 < shadow_len; i++) shadow_cells[i] = shadow_cells[i+1];
          shadow_len--;
        end
      end
      OP_CLEAR: begin
        shadow_len = 0;
        shadow_cur = 0;
      end
      OP_FIRST: shadow_cur = 0;
      OP_PREV:  if (shadow_cur > -1) shadow_cur--;      // saturates at -1
      OP_NEXT:  if (shadow_cur < DEPTH) shadow_cur++;   // saturates at DEPTH
      default:  shadow_cur = (int'(p) > DEPTH) ? DEPTH : int'(p);
    endcase
    r.len = CNT_W'(shadow_len);
    r.cur = CUR_W'(shadow_cur);
    return r;
  endfunction

  // Results still owed by the block, oldest first.
  list_result_t pending_results[$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and a field-by-field check of each transfer.
  // ---------------------------------------------------------------------------
  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (removed_value !== want.removed) flag_field("removed_value", want.removed, removed_value);
        if (length !== want.len)            flag_field("length", 32'(want.len), 32'(length));
        if (cursor_now !== want.cur)        flag_field("cursor_now", 32'(want.cur), 32'(cursor_now));
        if (error !== want.err)             flag_field("error", 32'(want.err), 32'(error));
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Valid is only lowered for a sender gap or a drain, never in the
  // step where the next item raises it again.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_t op, logic [31:0] v, logic [CNT_W-1:0] p, bit typed,
                           list_result_t want);
    list_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    value    <= v;
    position <= p;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge
    predicted = apply_list_op(op, v, p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Capacity is written only with the block idle; every item yields a result,
  // so an empty list of owed results means nothing is in flight.
  task automatic write_capacity(int cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(cap);
    @(posedge clk);
    cfg_we     <= 1'b0;
    shadow_cap = cap;
  endtask

  function automatic stim_row_t op_row(op_t op, logic [31:0] v, logic [CNT_W-1:0] p);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.op     = op;
    r.val    = v;
    r.pos    = p;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(op_t op, logic [31:0] v, logic [CNT_W-1:0] p,
                                          int len, int cur, bit err);
    stim_row_t r;
    r          = op_row(op, v, p);
    r.typed    = 1'b1;
    r.want.len = CNT_W'(len);
    r.want.cur = CUR_W'(cur);
    r.want.err = err;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(int cap);
    stim_row_t r;
    r        = op_row(OP_CLEAR, '0, '0);
    r.is_cfg = 1'b1;
    r.val    = 32'(cap);
    return r;
  endfunction

  // Random item shaped so most inserts and removes find a legal cursor.
  task automatic send_random_item();
    int               w;
    op_t              op;
    logic [31:0]      v;
    logic [CNT_W-1:0] p;
    w = $urandom_range(0, 99);
    if (w < 24)      op = OP_INSERT;
    else if (w < 40) op = OP_APPEND;
    else if (w < 64) op = OP_REMOVE;
    else if (w < 67) op = OP_CLEAR;
    else if (w < 73) op = OP_FIRST;
    else if (w < 80) op = OP_PREV;
    else if (w < 87) op = OP_NEXT;
    else             op = OP_SETPOS;
    w = $urandom_range(0, 9);
    v = (w == 0) ? 32'h0 : (w == 1) ? 32'hFFFF_FFFF : $urandom;
    p = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(0, shadow_len))
                                    : CNT_W'($urandom_range(0, 31));
    // cursor off the list: usually steer it back first instead
    if (((op == OP_INSERT && (shadow_cur < 0 || shadow_cur > shadow_len)) ||
         (op == OP_REMOVE && (shadow_cur < 0 || shadow_cur >= shadow_len))) &&
        $urandom_range(0, 3) != 0) begin
      op = OP_SETPOS;
      p  = CNT_W'($urandom_range(0, (shadow_len > 0) ? shadow_len - 1 : 0));
    end
    send_item(op, v, p, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t directed_rows[$];
    int        phase_cap   [NUM_PHASES] = '{16, 1, 31, 0, 4, 16, 2, -1};
    int        phase_items [NUM_PHASES] = '{90, 80, 90, 40, 80, 90, 80, 80};
    int        ph;
    int        k;
    int        cap;

    for (k = 0; k < DEPTH; k++) shadow_cells[k] = '0;

    // Reset capacity (16) for the opening rows.
    directed_rows.push_back(typed_row(OP_REMOVE, 32'h0, 5'd0, 0, 0, 1));   // remove on empty
    directed_rows.push_back(typed_row(OP_PREV,   32'h0, 5'd0, 0, -1, 0));
    directed_rows.push_back(typed_row(OP_PREV,   32'h0, 5'd0, 0, -1, 0));  // stays at -1
    directed_rows.push_back(typed_row(OP_INSERT, 32'h1, 5'd0, 0, -1, 1));  // cursor below 0
    directed_rows.push_back(typed_row(OP_FIRST,  32'h0, 5'd0, 0, 0, 0));
    directed_rows.push_back(typed_row(OP_INSERT, 32'hFFFF_FFFF, 5'd0, 1, 0, 0));
    directed_rows.push_back(typed_row(OP_INSERT, 32'h0, 5'd0, 2, 0, 0));
    directed_rows.push_back(typed_row(OP_APPEND, 32'hA5A5_5A5A, 5'd0, 3, 0, 0));
    directed_rows.push_back(op_row(OP_NEXT,   32'h0, 5'd0));
    directed_rows.push_back(op_row(OP_INSERT, 32'h1234_5678, 5'd0));       // insert mid-list
    directed_rows.push_back(typed_row(OP_SETPOS, 32'h0, 5'd31, 4, 16, 0)); // clamps to DEPTH
    directed_rows.push_back(typed_row(OP_NEXT,   32'h0, 5'd0, 4, 16, 0));  // stays at DEPTH
    directed_rows.push_back(typed_row(OP_INSERT, 32'h5, 5'd0, 4, 16, 1));  // cursor past length
    directed_rows.push_back(typed_row(OP_REMOVE, 32'h0, 5'd0, 4, 16, 1));
    directed_rows.push_back(op_row(OP_SETPOS, 32'h0, 5'd4));
    directed_rows.push_back(op_row(OP_REMOVE, 32'h0, 5'd0));               // cursor == length
    directed_rows.push_back(op_row(OP_PREV,   32'h0, 5'd0));
    directed_rows.push_back(op_row(OP_REMOVE, 32'h0, 5'd0));               // remove the tail
    // capacity lowered below the length: entries kept, growth refused
    directed_rows.push_back(cfg_row(2));
    directed_rows.push_back(typed_row(OP_APPEND, 32'h7, 5'd0, 3, 3, 1));
    directed_rows.push_back(op_row(OP_SETPOS, 32'h0, 5'd0));
    directed_rows.push_back(op_row(OP_REMOVE, 32'h0, 5'd0));
    directed_rows.push_back(typed_row(OP_INSERT, 32'h9, 5'd0, 2, 0, 1));   // full at capacity
    // capacity zero: every insert and append fails
    directed_rows.push_back(cfg_row(0));
    directed_rows.push_back(op_row(OP_REMOVE, 32'h0, 5'd0));
    directed_rows.push_back(typed_row(OP_APPEND, 32'h3, 5'd0, 1, 0, 1));
    directed_rows.push_back(typed_row(OP_CLEAR,  32'h0, 5'd0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_capacity(int'(directed_rows[i].val));
      else
        send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].pos,
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases: capacity changes between phases, list contents carry over.
    // Idling rotates through none / sender only / receiver only / both.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      cap = (phase_cap[ph] < 0) ? $urandom_range(0, 31) : phase_cap[ph];
      write_capacity(cap);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (k = 0; k < phase_items[ph]; k++) begin
        if (k == phase_items[ph] / 2) drain_results();
        send_random_item();
      end
    end

    // Done sending: let the owed results come back, then wait with no traffic
    // to catch any stray transfer.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
